@@ hw/rtl/bia_pkg.sv @@
package bia_pkg;

    // operation codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_TEST  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BYTES = 8'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] id_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] granted_id;
        logic        is_used;
    } t_out_word;

endpackage

@@ hw/rtl/bia_map_ram.sv @@
module bia_map_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 64,
    parameter int unsigned AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bia_core.sv @@
module bia_core #(
    parameter int unsigned MAP_BITS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  bia_pkg::t_in_word      i_in_word,
    input  logic [31:0]            i_base_id,
    input  logic [$clog2(MAP_BITS):0] i_nbits,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output bia_pkg::t_out_word     o_res_word,
    output logic                   o_mem_we,
    output logic [((MAP_BITS <= 64) ? 1 : $clog2(MAP_BITS / 64))-1:0] o_mem_waddr,
    output logic [((MAP_BITS < 64) ? MAP_BITS : 64)-1:0]              o_mem_wdata,
    output logic                   o_mem_re,
    output logic [((MAP_BITS <= 64) ? 1 : $clog2(MAP_BITS / 64))-1:0] o_mem_raddr,
    input  logic [((MAP_BITS < 64) ? MAP_BITS : 64)-1:0]              i_mem_rdata
);

    import bia_pkg::*;

    localparam int unsigned WORD_BITS = (MAP_BITS < 64) ? MAP_BITS : 64;
    localparam int unsigned NUM_WORDS = MAP_BITS / WORD_BITS;
    localparam int unsigned AW        = (MAP_BITS <= 64) ? 1 : $clog2(MAP_BITS / 64);
    localparam int unsigned BW        = $clog2(WORD_BITS);
    localparam int unsigned NBITS_W   = $clog2(MAP_BITS) + 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr,  n_addr;
    logic [1:0]      r_func,  n_func;
    logic [BW-1:0]   r_bit,   n_bit;
    t_out_word       r_res,   n_res;

    logic [31:0]          off;
    logic                 in_range;
    logic [NBITS_W-1:0]   word_start;
    logic [NBITS_W-1:0]   word_end;
    logic [NBITS_W-1:0]   remain;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic                 free_any;
    logic [BW-1:0]        free_idx;
    logic                 last_word;
    logic [AW+BW-1:0]     grant_k;

    // identifier offset against the window, valid only while accepting
    assign off      = i_in_word.id_value - i_base_id;
    assign in_range = off < 32'(i_nbits);

    assign word_start = NBITS_W'({r_addr, {BW{1'b0}}});
    assign word_end   = word_start + NBITS_W'(WORD_BITS);
    assign last_word  = i_nbits <= word_end;
    assign remain     = (i_nbits > word_start) ? (i_nbits - word_start) : '0;

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            valid_mask[j] = NBITS_W'(j) < remain;
        end
    end

    assign free_bits = ~i_mem_rdata & valid_mask;
    assign free_any  = |free_bits;

    // lowest free bit of the current word
    always_comb begin
        free_idx = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                free_idx = BW'(j);
            end
        end
    end

    assign grant_k = {r_addr, free_idx};

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_func      = r_func;
        n_bit       = r_bit;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_addr;

        unique case (r_state)
            S_CLEAR: begin
                o_mem_we = 1'b1;
                n_addr   = r_addr + AW'(1);
                if (r_addr == AW'(NUM_WORDS - 1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func = i_in_word.func;
                    n_bit  = off[BW-1:0];
                    n_res  = '{status: STATUS_OK, granted_id: '0, is_used: 1'b0};
                    if (i_in_word.func == FUNC_ALLOC) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = '0;
                        n_addr      = '0;
                        n_state     = S_EVAL;
                    end else if ((i_in_word.func == FUNC_FREE ||
                                  i_in_word.func == FUNC_TEST) && in_range) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = off[BW +: AW];
                        n_addr      = off[BW +: AW];
                        n_state     = S_EVAL;
                    end else begin
                        n_res.status = STATUS_RANGE;
                        n_state      = S_DONE;
                    end
                end
            end
            S_EVAL: begin
                case (r_func)
                    FUNC_ALLOC: begin
                        if (free_any) begin
                            o_mem_we         = 1'b1;
                            o_mem_wdata      = i_mem_rdata | (WORD_BITS'(1) << free_idx);
                            n_res.granted_id = r_res.granted_id + i_base_id
                                               + 32'(grant_k);
                            n_state          = S_DONE;
                        end else if (last_word) begin
                            n_res.status = STATUS_FULL;
                            n_state      = S_DONE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = r_addr + AW'(1);
                            n_addr      = r_addr + AW'(1);
                        end
                    end
                    FUNC_FREE: begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = i_mem_rdata & ~(WORD_BITS'(1) << r_bit);
                        n_state     = S_DONE;
                    end
                    FUNC_TEST: begin
                        n_res.is_used = i_mem_rdata[r_bit];
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_res.status = STATUS_RANGE;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_bit  <= n_bit;
        r_res  <= n_res;
    end

    assign o_res_word = r_res;

endmodule

@@ hw/rtl/bitmap_id_allocator_top.sv @@
// First-free identifier allocator. A used-bit map of MAP_BITS bits covers the
// identifiers base_id .. base_id + 8*active_bytes - 1 (modulo 2^32; a byte
// count above MAP_BITS/8 counts as MAP_BITS/8). func 0 allocates the lowest
// free identifier, func 1 frees one and func 2 tests one; each input word
// gives exactly one result word. The map lives in a single-port-read,
// single-port-write RAM of 64-bit words (MAP_BITS/64 words, or one word of
// MAP_BITS bits when MAP_BITS is below 64). After reset the block writes zeros
// to every map word through the RAM and takes no input word meanwhile; config
// writes are taken at any time but must only be issued while the block is
// idle. Steps per word, from accept to result ready in the output register:
// allocate reads the map words in turn, one per cycle, from word 0 until a
// free bit is found or the last active word is read, then sets that bit;
// free and test read the addressed word, then free modifies and writes it
// back while test reports the bit; an out-of-range or unused operation reads
// no map word. One word is in flight at a time, but a finished result waits
// in the output register so the next word can start while the sink stalls.
module bitmap_id_allocator_top #(
    parameter int unsigned MAP_BITS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bia_pkg::t_in_word               i_in_word,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bia_pkg::t_out_word              o_out_word,
    // config writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bia_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    import bia_pkg::*;

    localparam int unsigned WORD_BITS = (MAP_BITS < 64) ? MAP_BITS : 64;
    localparam int unsigned NUM_WORDS = MAP_BITS / WORD_BITS;
    localparam int unsigned AW        = (MAP_BITS <= 64) ? 1 : $clog2(MAP_BITS / 64);
    localparam int unsigned NBITS_W   = $clog2(MAP_BITS) + 1;
    localparam int unsigned MAX_BYTES = MAP_BITS / 8;

    // config registers
    logic [31:0] r_base_id;
    logic [7:0]  r_active_bytes;

    // output register
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic               res_valid;
    logic               res_ready;
    t_out_word          res_word;
    logic [NBITS_W-1:0] nbits;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id      <= '0;
            r_active_bytes <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE_ID:      r_base_id      <= i_cfg_data;
                CFG_ACTIVE_BYTES: r_active_bytes <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // active bit count, clamped to the map size
    assign nbits = (32'(r_active_bytes) > 32'(MAX_BYTES)) ? NBITS_W'(MAP_BITS)
                                                          : NBITS_W'({r_active_bytes, 3'b000});

    bia_core #(
        .MAP_BITS (MAP_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_base_id   (r_base_id),
        .i_nbits     (nbits),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_word  (res_word),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    bia_map_ram #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result moves into the output register when it is empty or draining
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
